### rtl/weyl_mix_random_generator_macros.svh
// ----------------------------------------------------------------------------
// Weyl mix random generator assertion macros
// Shared concurrent assertion forms used by the generator RTL.
// ----------------------------------------------------------------------------
`ifndef WEYL_MIX_RANDOM_GENERATOR_MACROS_SVH
`define WEYL_MIX_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WMR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/wmrg_pkg.sv
// ----------------------------------------------------------------------------
// Weyl mix random generator package
// Transaction types, mixer constants, mode and status codes, sequencer states.
// ----------------------------------------------------------------------------
package wmrg_pkg;

  localparam logic [63:0] WEYL_MUL  = 64'h61c8864680b583eb;
  localparam logic [63:0] WEYL_STEP = 64'h4f1bbcdcbfa54001;
  localparam logic [63:0] MIX_MUL_A = 64'h7fb5d329728ea185;
  localparam logic [63:0] MIX_MUL_B = 64'h81dadef4bc2dd44d;

  localparam int unsigned MIX_SH_A  = 31;
  localparam int unsigned MIX_SH_B  = 27;
  localparam int unsigned MIX_SH_C  = 33;
  localparam int unsigned FRAC_BITS = 50;

  localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

  // A 64x64 low-half product from three 32x32 partial products.
  localparam logic [1:0] MUL_LAST = 2'd2;

  // Restoring remainder, one dividend bit per step.
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  localparam logic [1:0] MODE_RAW   = 2'd0;
  localparam logic [1:0] MODE_FRAC  = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [63:0] lower;
    logic signed [63:0] upper;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_X1,
    ST_M1,
    ST_X2,
    ST_M2,
    ST_X3,
    ST_CHECK,
    ST_DIV,
    ST_ADJ,
    ST_FIN
  } seq_state_t;

endpackage

### rtl/weyl_mix_random_generator.sv
// ----------------------------------------------------------------------------
// Weyl mix random generator
// Sequence: mixer states X1, M1, X2, M2 and X3, then CHECK and FIN in raw, fraction and
//   error cases; a bounded interval runs the remainder steps (DIV) and ADJ before FIN.
// Busy: no new transaction is taken until the last one has left FIN for IDLE; a seed
//   write keeps the block busy through PRE and the mixer (shared 32x32 multiplier).
// Reset: synchronous, rst_n low; generator state returns to that of seed zero.
// ----------------------------------------------------------------------------
`include "weyl_mix_random_generator_macros.svh"

module weyl_mix_random_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  wmrg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wmrg_pkg::out_item_t out_data
);

  import wmrg_pkg::*;

  // Sequencer state and control registers.
  seq_state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic seeding_r, seeding_nxt;
  logic out_valid_r, out_valid_nxt;

  // The Weyl counter is architectural state, so it is reset.
  logic [63:0] gen_state_r, gen_state_nxt;

  // Datapath registers.
  logic [63:0] z_r, z_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] div_r, div_nxt;
  in_item_t    item_r, item_nxt;
  out_item_t   res_r, res_nxt;
  out_item_t   out_data_r, out_data_nxt;

  // Shared multiplier: one 32x32 product per cycle.
  logic [63:0] mul_k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // Interval checks for bounded mode.
  logic        range_empty;
  logic [63:0] span;
  logic        range_ok;

  // Remainder step.
  logic [63:0] trial;
  logic        trial_ge;

  logic in_fire;
  logic out_free;
  logic mul_state;
  logic rem_live;
  logic fin_go;

  assign in_ready  = (state_r == ST_IDLE) && !cfg_wr_en;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign mul_state = (state_r == ST_PRE) || (state_r == ST_M1) || (state_r == ST_M2);
  assign rem_live  = (state_r == ST_DIV) || (state_r == ST_ADJ);
  assign fin_go    = (state_r == ST_FIN) && out_free && !cfg_wr_en;

  // Signed order check, then the span must fit in 63 bits so span+1 stays a
  // valid unsigned divisor.
  assign range_empty = item_r.upper < item_r.lower;
  assign span        = 64'(item_r.upper - item_r.lower);
  assign range_ok    = !range_empty && !span[63];

  // The remainder is always below the divisor, which is at most 2^63, so the
  // shifted remainder fits in 64 bits.
  assign trial    = {rem_r[62:0], z_r[63]};
  assign trial_ge = trial >= div_r;

  // Constant and partial-product selection for the shared multiplier.
  always_comb begin
    case (state_r)
      ST_PRE:  mul_k = WEYL_MUL;
      ST_M1:   mul_k = MIX_MUL_A;
      default: mul_k = MIX_MUL_B;
    endcase
    case (step_r)
      2'd0: begin
        mul_a = z_r[31:0];
        mul_b = mul_k[31:0];
      end
      2'd1: begin
        mul_a = z_r[31:0];
        mul_b = mul_k[63:32];
      end
      default: begin
        mul_a = z_r[63:32];
        mul_b = mul_k[31:0];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Next-state logic. A seed write restarts the sequencer from any state.
  always_comb begin
    state_nxt = state_r;
    if (cfg_wr_en) begin
      state_nxt = ST_PRE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_nxt = ST_X1;
          end
        end
        ST_PRE: begin
          if (step_r == MUL_LAST) begin
            state_nxt = ST_X1;
          end
        end
        ST_X1: state_nxt = ST_M1;
        ST_M1: begin
          if (step_r == MUL_LAST) begin
            state_nxt = ST_X2;
          end
        end
        ST_X2: state_nxt = ST_M2;
        ST_M2: begin
          if (step_r == MUL_LAST) begin
            state_nxt = ST_X3;
          end
        end
        ST_X3: state_nxt = seeding_r ? ST_IDLE : ST_CHECK;
        ST_CHECK: begin
          if ((item_r.mode == MODE_RANGE) && range_ok) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_FIN;
          end
        end
        ST_DIV: begin
          if (cnt_r == DIV_LAST) begin
            state_nxt = ST_ADJ;
          end
        end
        ST_ADJ: state_nxt = ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state_nxt = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // Datapath and output register updates.
  always_comb begin
    step_nxt      = 2'd0;
    cnt_nxt       = cnt_r;
    seeding_nxt   = seeding_r;
    gen_state_nxt = gen_state_r;
    z_nxt         = z_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (mul_state && (step_r != MUL_LAST)) begin
      step_nxt = step_r + 2'd1;
    end

    if (cfg_wr_en) begin
      // The seed is first multiplied by the Weyl multiplier, then mixed.
      z_nxt       = cfg_wr_data;
      seeding_nxt = 1'b1;
      step_nxt    = 2'd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            item_nxt      = in_data;
            z_nxt         = gen_state_r;
            gen_state_nxt = gen_state_r + WEYL_STEP;
            seeding_nxt   = 1'b0;
          end
        end
        ST_PRE, ST_M1, ST_M2: begin
          // Low 64 bits of z * k: lo*lo, then both cross terms into the top half.
          case (step_r)
            2'd0:    acc_nxt = mul_p;
            2'd1:    acc_nxt = {acc_r[63:32] + mul_p[31:0], acc_r[31:0]};
            default: z_nxt   = {acc_r[63:32] + mul_p[31:0], acc_r[31:0]};
          endcase
        end
        ST_X1: z_nxt = z_r ^ (z_r >> MIX_SH_A);
        ST_X2: z_nxt = z_r ^ (z_r >> MIX_SH_B);
        ST_X3: begin
          if (seeding_r) begin
            gen_state_nxt = (z_r ^ (z_r >> MIX_SH_C)) + WEYL_STEP;
          end else begin
            z_nxt = z_r ^ (z_r >> MIX_SH_C);
          end
        end
        ST_CHECK: begin
          rem_nxt        = 64'd0;
          cnt_nxt        = '0;
          div_nxt        = span + 64'd1;
          res_nxt.status = STATUS_OK;
          case (item_r.mode)
            MODE_FRAC:  res_nxt.value = z_r & FRAC_MASK;
            MODE_RANGE: begin
              res_nxt.value = 64'd0;
              if (range_empty) begin
                res_nxt.status = STATUS_EMPTY;
              end else if (span[63]) begin
                res_nxt.status = STATUS_TOO_LARGE;
              end
            end
            default:    res_nxt.value = z_r;
          endcase
        end
        ST_DIV: begin
          rem_nxt = trial_ge ? (trial - div_r) : trial;
          z_nxt   = {z_r[62:0], 1'b0};
          cnt_nxt = cnt_r + DIV_CNT_W'(1);
        end
        ST_ADJ: begin
          res_nxt.value  = rem_r + item_r.lower;
          res_nxt.status = STATUS_OK;
        end
        ST_FIN: begin
          if (out_free) begin
            out_data_nxt  = res_r;
            out_valid_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 2'd0;
      cnt_r       <= '0;
      seeding_r   <= 1'b0;
      out_valid_r <= 1'b0;
      gen_state_r <= WEYL_STEP;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      seeding_r   <= seeding_nxt;
      out_valid_r <= out_valid_nxt;
      gen_state_r <= gen_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r        <= z_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // An accepted transaction keeps the block busy on the following cycle.
  `WMR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready, "ready after accept")
  // The divisor is never zero while the remainder unit runs.
  `WMR_ASSERT_NOW(a_div_nonzero, clk, rst_n, state_r == ST_DIV, div_r != 64'd0, "zero divisor")
  // The partial remainder stays below the divisor through the final adjust.
  `WMR_ASSERT_NOW(a_rem_bound, clk, rst_n, rem_live, rem_r < div_r, "remainder not reduced")
  // A finished result moves into the output register once the slot is free.
  `WMR_ASSERT_NEXT(a_fin_delivers, clk, rst_n, fin_go, out_valid_r, "result not presented")

endmodule
